/* hw/rtl/blp_pkg.sv */
`timescale 1ns / 1ps

package blp_pkg;

  localparam int ENTRY_W = 16;
  localparam int COUNT_W = 5;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_INSERT_AT  = 3'd4;
  localparam logic [2:0] OP_DELETE_AT  = 3'd5;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [ENTRY_W-1:0] pass;
    logic [ENTRY_W-1:0] seats;
    logic [ENTRY_W-1:0] num;
  } entry_t;

  // Per-cell control: the operation broadcast along the chain and where this
  // cell sits relative to the target slot.
  typedef struct packed {
    logic open_gap;
    logic close_gap;
    logic at_or_after;
    logic at_target;
  } cell_ctl_t;

endpackage

/* hw/rtl/blp_cell.sv */
`timescale 1ns / 1ps

module blp_cell (
  input  logic             clk,
  input  blp_pkg::cell_ctl_t ctl,
  input  blp_pkg::entry_t  fresh,
  input  blp_pkg::entry_t  from_left,
  input  blp_pkg::entry_t  from_right,
  output blp_pkg::entry_t  slot,
  output blp_pkg::entry_t  tap
);
  import blp_pkg::*;

  entry_t slot_r;
  entry_t slot_nxt;

  always_comb begin
    slot_nxt = slot_r;
    if (ctl.open_gap) begin
      if (ctl.at_target) begin
        slot_nxt = fresh;
      end else if (ctl.at_or_after) begin
        slot_nxt = from_left;
      end
    end else if (ctl.close_gap && ctl.at_or_after) begin
      slot_nxt = from_right;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign slot = slot_r;
  // The removed entry leaves through an OR tree, so idle cells give zero.
  assign tap  = (ctl.close_gap && ctl.at_target) ? slot_r : '0;

endmodule

/* hw/rtl/bounded_positional_list_top.sv */
`timescale 1ns / 1ps
// The result word of an accepted input word is registered and shows in the next cycle.
// Throughput: one operation per cycle; every cell after the target slot shifts
// away from or towards it, and the target cell is loaded, in that same cycle.
// A new word is taken only when the output register is empty or its word leaves.
// Reset (synchronous, rst_n low) empties the list; slot contents are kept.
module bounded_positional_list_top #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // op[2:0], position[10:3], car_number[26:11], seat_count[42:27],
  // passenger_count[58:43], zero fill [63:59]
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0], entry_count[6:2], removed_number[22:7], removed_seats[38:23],
  // removed_passengers[54:39], zero fill [55]
  output logic [55:0] out_tdata
);
  import blp_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic            accept;
  logic [2:0]      op;
  logic signed [7:0] pos;
  entry_t          fresh;
  logic [CW-1:0]   held_r;
  logic [CW-1:0]   held_nxt;
  logic [CW-1:0]   at;
  logic            do_open;
  logic            do_close;
  logic [1:0]      status;
  logic [7:0]      held8;
  logic            pos_ge_held;

  entry_t          slot  [CAPACITY];
  entry_t          tap   [CAPACITY];
  cell_ctl_t       ctl   [CAPACITY];
  entry_t          removed;

  logic            out_valid_r;
  logic [1:0]      status_r;
  logic [COUNT_W-1:0] count_r;
  entry_t          removed_r;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign op          = in_tdata[2:0];
  assign pos         = in_tdata[10:3];
  assign fresh.num   = in_tdata[26:11];
  assign fresh.seats = in_tdata[42:27];
  assign fresh.pass  = in_tdata[58:43];

  assign held8       = 8'(held_r);
  assign pos_ge_held = !pos[7] && (pos >= $signed(held8));

  always_comb begin
    do_open  = 1'b0;
    do_close = 1'b0;
    status   = ST_DONE;
    at       = '0;
    held_nxt = held_r;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT: begin
        if (held_r >= CW'(CAPACITY)) begin
          status = ST_FULL;
        end else begin
          do_open  = 1'b1;
          held_nxt = held_r + 1'b1;
          if (op == OP_PUSH_FRONT) begin
            at = '0;
          end else if (op == OP_PUSH_BACK) begin
            at = held_r;
          end else if (pos[7] || pos == 8'sd0) begin
            at = '0;
          end else if (pos_ge_held) begin
            at = held_r;
          end else begin
            at = CW'(pos[6:0]);
          end
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (held_r == '0) begin
          status = ST_EMPTY;
        end else begin
          do_close = 1'b1;
          held_nxt = held_r - 1'b1;
          at       = (op == OP_POP_FRONT) ? '0 : held_r - 1'b1;
        end
      end
      OP_DELETE_AT: begin
        if (pos[7] || pos_ge_held) begin
          status = ST_RANGE;
        end else begin
          do_close = 1'b1;
          held_nxt = held_r - 1'b1;
          at       = CW'(pos[6:0]);
        end
      end
      default: begin
      end
    endcase
  end

  genvar k;
  generate
    for (k = 0; k < CAPACITY; k++) begin : g_cell
      entry_t left_in;
      entry_t right_in;

      assign ctl[k].open_gap    = accept && do_open;
      assign ctl[k].close_gap   = accept && do_close;
      assign ctl[k].at_or_after = CW'(k) >= at;
      assign ctl[k].at_target   = CW'(k) == at;

      if (k == 0) begin : g_first
        assign left_in = fresh;
      end else begin : g_mid_l
        assign left_in = slot[k-1];
      end
      if (k == CAPACITY - 1) begin : g_last
        assign right_in = slot[k];
      end else begin : g_mid_r
        assign right_in = slot[k+1];
      end

      blp_cell u_cell (
        .clk        (clk),
        .ctl        (ctl[k]),
        .fresh      (fresh),
        .from_left  (left_in),
        .from_right (right_in),
        .slot       (slot[k]),
        .tap        (tap[k])
      );
    end
  endgenerate

  always_comb begin
    removed = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      removed = removed | tap[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        held_r      <= held_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status;
      count_r   <= COUNT_W'(held_nxt);
      removed_r <= removed;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, removed_r.pass, removed_r.seats, removed_r.num,
                       count_r, status_r};

endmodule

/* tb/sv/bounded_positional_list_checker.sv */
`timescale 1ns / 1ps

module bounded_positional_list_checker #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  output int          fail_count,
  output int          pending_count,
  output int          checked_count,
  output int          full_reports
);
  import blp_pkg::*;

  // Input word layout from the lowest bit up: op, position, then the entry.
  typedef struct packed {
    entry_t     fresh;
    logic [7:0] pos;
    logic [2:0] op;
  } op_word_t;

  // Result word layout from the lowest bit up: status, count, removed entry.
  typedef struct packed {
    entry_t     gone;
    logic [4:0] count;
    logic [1:0] status;
  } list_result_t;

  entry_t       list_slots [CAPACITY];
  int           list_held = 0;
  list_result_t expected_results_q [$];
  int           fail_tally = 0;
  int           checked_tally = 0;
  int           full_tally = 0;

  function automatic entry_t remove_slot(input int slot);
    entry_t gone;
    gone = list_slots[slot];
    for (int k = slot; k + 1 < list_held; k++) list_slots[k] = list_slots[k + 1];
    list_held--;
    return gone;
  endfunction

  function automatic list_result_t apply_list_op(input op_word_t word);
    list_result_t res;
    int           pos;
    int           slot;
    res = '0;
    res.status = ST_DONE;
    pos = int'($signed(word.pos));
    case (word.op)
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT: begin
        if (list_held >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          if (word.op == OP_PUSH_FRONT) slot = 0;
          else if (word.op == OP_PUSH_BACK) slot = list_held;
          else if (pos <= 0) slot = 0;
          else if (pos >= list_held) slot = list_held;
          else slot = pos;
          for (int k = list_held; k > slot; k--) list_slots[k] = list_slots[k - 1];
          list_slots[slot] = word.fresh;
          list_held++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (list_held == 0) res.status = ST_EMPTY;
        else res.gone = remove_slot((word.op == OP_POP_FRONT) ? 0 : list_held - 1);
      end
      OP_DELETE_AT: begin
        if (pos < 0 || pos >= list_held) res.status = ST_RANGE;
        else res.gone = remove_slot(pos);
      end
      default: begin
      end
    endcase
    res.count = list_held[4:0];
    return res;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      fail_tally++;
    end
  endtask

  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (rst_n) begin
      // The result word leaves before the next input word is predicted, so a
      // stray result can never be matched against a fresh expectation.
      if (out_tvalid && out_tready) begin
        got = list_result_t'(out_tdata[54:0]);
        if (expected_results_q.size() == 0) begin
          $error("result word 0x%0h arrived with no expectation waiting", out_tdata);
          fail_tally++;
        end else begin
          want = expected_results_q.pop_front();
          check_field("status", want.status, got.status);
          check_field("entry_count", want.count, got.count);
          check_field("removed_number", want.gone.num, got.gone.num);
          check_field("removed_seats", want.gone.seats, got.gone.seats);
          check_field("removed_passengers", want.gone.pass, got.gone.pass);
          if (want.status == ST_FULL) full_tally++;
          checked_tally++;
        end
      end
      if (in_tvalid && in_tready) expected_results_q.push_back(apply_list_op(in_tdata[58:0]));
    end
    fail_count    <= fail_tally;
    pending_count <= expected_results_q.size();
    checked_count <= checked_tally;
    full_reports  <= full_tally;
  end

endmodule

/* tb/sv/bounded_positional_list_top_tb.sv */
`timescale 1ns / 1ps

module bounded_positional_list_top_tb;
  import blp_pkg::*;

  localparam int         LIST_DEPTH   = 16;
  localparam int         HOLD_CYCLES  = 60;
  localparam int         PHASE_ITEMS  = 176;
  localparam logic [2:0] OP_SPARE_LO  = 3'd6;
  localparam logic [2:0] OP_SPARE_HI  = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;

  int fail_count;
  int pending_count;
  int checked_count;
  int full_reports;

  int send_idle_pct = 31;
  int recv_idle_pct = 75;
  int words_sent = 0;
  bit hold_request = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bounded_positional_list_top #(
    .CAPACITY(LIST_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  bounded_positional_list_checker #(
    .CAPACITY(LIST_DEPTH)
  ) list_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .pending_count(pending_count),
    .checked_count(checked_count),
    .full_reports (full_reports)
  );

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input logic [2:0] op, input logic [7:0] pos,
                           input logic [15:0] num, input logic [15:0] seats,
                           input logic [15:0] pass);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, pass, seats, num, pos, op};
    do @(posedge clk); while (!in_tready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_op(input int grow_pct);
    logic [2:0] op;
    logic [7:0] pos;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 3) begin
      op = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
    end else if (pick < 3 + grow_pct) begin
      case ($urandom_range(2))
        0: op = OP_PUSH_FRONT;
        1: op = OP_PUSH_BACK;
        default: op = OP_INSERT_AT;
      endcase
    end else begin
      case ($urandom_range(2))
        0: op = OP_POP_FRONT;
        1: op = OP_POP_BACK;
        default: op = OP_DELETE_AT;
      endcase
    end
    // Positions mostly land around the live range so that the middle of the
    // list is exercised; the rest roam the whole signed field.
    if ($urandom_range(3) != 0) pos = 8'($urandom_range(0, LIST_DEPTH + 1));
    else pos = 8'($urandom_range(255));
    send_word(op, pos, 16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
              16'($urandom_range(16'hFFFF)));
  endtask

  // Bursts that lean towards growing, shrinking or neither walk the list
  // between empty and full many times over.
  task automatic run_phase(input int items, input bit with_hold);
    int target;
    int grow_pct;
    int burst;
    target = words_sent + items;
    while (words_sent < target) begin
      case ($urandom_range(2))
        0: grow_pct = 85;
        1: grow_pct = 12;
        default: grow_pct = 48;
      endcase
      burst = $urandom_range(10, 40);
      repeat (burst) begin
        if (words_sent < target) begin
          if (with_hold && words_sent == target - items + 20) hold_request = 1'b1;
          send_random_op(grow_pct);
        end
      end
    end
  endtask

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #200000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Operations on the empty list.
    send_word(OP_POP_FRONT, 0, 16'h0, 16'h0, 16'h0);
    send_word(OP_POP_BACK, 0, 16'h0, 16'h0, 16'h0);
    send_word(OP_DELETE_AT, 0, 16'h0, 16'h0, 16'h0);
    // Growth at both ends, with insert positions clamped to either end.
    send_word(OP_PUSH_FRONT, 0, 16'h0000, 16'h0000, 16'h0000);
    send_word(OP_PUSH_BACK, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(OP_INSERT_AT, -128, 16'h1111, 16'h2222, 16'h3333);
    send_word(OP_INSERT_AT, 127, 16'h4444, 16'h5555, 16'h6666);
    send_word(OP_INSERT_AT, 2, 16'hA5A5, 16'h5A5A, 16'hC3C3);
    send_word(OP_INSERT_AT, 5, 16'h8001, 16'h7FFE, 16'h0F0F);
    send_word(OP_INSERT_AT, 0, 16'h1234, 16'h5678, 16'h9ABC);
    // Deletes outside the range leave the list alone.
    send_word(OP_DELETE_AT, -1, 16'h0, 16'h0, 16'h0);
    send_word(OP_DELETE_AT, 7, 16'h0, 16'h0, 16'h0);
    send_word(OP_DELETE_AT, 127, 16'h0, 16'h0, 16'h0);
    send_word(OP_DELETE_AT, -128, 16'h0, 16'h0, 16'h0);
    // Deletes in the middle, at the back and at the front.
    send_word(OP_DELETE_AT, 3, 16'h0, 16'h0, 16'h0);
    send_word(OP_DELETE_AT, 5, 16'h0, 16'h0, 16'h0);
    send_word(OP_DELETE_AT, 0, 16'h0, 16'h0, 16'h0);
    send_word(OP_SPARE_LO, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(OP_SPARE_HI, -1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(OP_POP_FRONT, 0, 16'h0, 16'h0, 16'h0);
    send_word(OP_POP_BACK, 0, 16'h0, 16'h0, 16'h0);

    run_phase(PHASE_ITEMS, 1'b0);
    send_idle_pct = 75;
    recv_idle_pct = 31;
    run_phase(PHASE_ITEMS, 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(PHASE_ITEMS, 1'b1);

    in_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Sent %0d list words over three idling phases and one long output hold-off.",
             words_sent);
    $display("Checked %0d result words, %0d of them refused because the list was full.",
             checked_count, full_reports);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/blp_pkg.sv
hw/rtl/blp_cell.sv
hw/rtl/bounded_positional_list_top.sv
tb/sv/bounded_positional_list_checker.sv
tb/sv/bounded_positional_list_top_tb.sv
